[hdl/mcfe_pkg.sv]
`default_nettype none
package mcfe_pkg;

  localparam int NUM_LANES = 5;
  localparam int RAW_W     = 16;
  localparam int LIN_W     = 41;
  localparam int T_W       = 29;
  localparam int M_W       = 30;
  localparam int PROD_W    = T_W + M_W;

  typedef enum logic [1:0] {
    MODE_MOTION  = 2'd0,
    MODE_ENABLE  = 2'd1,
    MODE_DISABLE = 2'd2,
    MODE_ZERO    = 2'd3
  } mode_e;

  typedef enum logic [2:0] {
    LANE_TORQUE   = 3'd0,
    LANE_ANGLE    = 3'd1,
    LANE_VELOCITY = 3'd2,
    LANE_KP       = 3'd3,
    LANE_KD       = 3'd4
  } lane_e;

  localparam logic [4:0] TYPE_MOTION  = 5'd1;
  localparam logic [4:0] TYPE_ENABLE  = 5'd3;
  localparam logic [4:0] TYPE_DISABLE = 5'd4;
  localparam logic [4:0] TYPE_ZERO    = 5'd6;

  // divisor S per lane: value range spans S*65536 before scaling
  localparam longint TQ_S = 120;
  localparam longint AN_S = 2514;
  localparam longint VE_S = 40;
  localparam longint KP_S = 5000;
  localparam longint KD_S = 100;

  // reciprocal shifts: dividend width plus ceil(log2(S))
  localparam int TQ_K = T_W + 7;
  localparam int AN_K = T_W + 12;
  localparam int VE_K = T_W + 6;
  localparam int KP_K = T_W + 13;
  localparam int KD_K = T_W + 7;

  localparam logic [M_W-1:0] TQ_M = M_W'(((64'd1 << TQ_K) + TQ_S - 1) / TQ_S);
  localparam logic [M_W-1:0] AN_M = M_W'(((64'd1 << AN_K) + AN_S - 1) / AN_S);
  localparam logic [M_W-1:0] VE_M = M_W'(((64'd1 << VE_K) + VE_S - 1) / VE_S);
  localparam logic [M_W-1:0] KP_M = M_W'(((64'd1 << KP_K) + KP_S - 1) / KP_S);
  localparam logic [M_W-1:0] KD_M = M_W'(((64'd1 << KD_K) + KD_S - 1) / KD_S);

  typedef logic [RAW_W-1:0] raw_t;
  typedef raw_t [NUM_LANES-1:0] raw_vec_t;

  typedef struct packed {
    logic [6:0]     q;
    logic [27:0]    off;
    logic [T_W-1:0] hi;
    logic [M_W-1:0] m;
    logic [5:0]     k;
  } lane_cfg_t;

  typedef struct packed {
    logic s1;
    logic s2;
    logic s3;
    logic so;
  } stage_en_t;

  typedef struct packed {
    mode_e      mode;
    logic [7:0] addr;
    logic       cf;
  } side_t;

  function automatic lane_cfg_t lane_cfg(lane_e lane);
    lane_cfg_t c;
    c = '0;
    case (lane)
      LANE_TORQUE: begin
        c.q = 7'd1; c.off = 28'(TQ_S / 2 * 65536); c.hi = T_W'(TQ_S * 65536);
        c.m = TQ_M; c.k = 6'(TQ_K);
      end
      LANE_ANGLE: begin
        c.q = 7'd100; c.off = 28'(AN_S / 2 * 65536); c.hi = T_W'(AN_S * 65536);
        c.m = AN_M; c.k = 6'(AN_K);
      end
      LANE_VELOCITY: begin
        c.q = 7'd1; c.off = 28'(VE_S / 2 * 65536); c.hi = T_W'(VE_S * 65536);
        c.m = VE_M; c.k = 6'(VE_K);
      end
      LANE_KP: begin
        c.q = 7'd1; c.off = 28'd0; c.hi = T_W'(KP_S * 65536);
        c.m = KP_M; c.k = 6'(KP_K);
      end
      LANE_KD: begin
        c.q = 7'd1; c.off = 28'd0; c.hi = T_W'(KD_S * 65536);
        c.m = KD_M; c.k = 6'(KD_K);
      end
      default: c = '0;
    endcase
    return c;
  endfunction

endpackage
`default_nettype wire

[hdl/mcfe_if.sv]
`default_nettype none
interface mcfe_cmd_if;
  logic        valid;
  logic        ready;
  logic [1:0]  mode;
  logic [7:0]  motor_address;
  logic        fault_clr;
  logic [31:0] torque_cmd;
  logic [31:0] angle_cmd;
  logic [31:0] velocity_cmd;
  logic [31:0] stiffness_gain;
  logic [31:0] damping_gain;

  modport source (
    output valid, mode, motor_address, fault_clr, torque_cmd, angle_cmd,
           velocity_cmd, stiffness_gain, damping_gain,
    input  ready
  );
  modport sink (
    input  valid, mode, motor_address, fault_clr, torque_cmd, angle_cmd,
           velocity_cmd, stiffness_gain, damping_gain,
    output ready
  );
endinterface

interface mcfe_frame_if;
  logic        valid;
  logic        ready;
  logic [28:0] frame_id;
  logic [63:0] frame_payload;

  modport source (output valid, frame_id, frame_payload, input ready);
  modport sink (input valid, frame_id, frame_payload, output ready);
endinterface
`default_nettype wire

[hdl/mcfe_lane.sv]
`default_nettype none
module mcfe_lane import mcfe_pkg::*; (
  input  wire logic             clk_i,
  input  wire lane_e            lane_i,
  input  wire stage_en_t        en_i,
  input  wire logic signed [31:0] x_i,
  output logic [RAW_W-1:0]      raw_o
);

  lane_cfg_t cfg;
  assign cfg = lane_cfg(lane_i);

  logic signed [LIN_W-1:0] lin_d, lin_q;
  logic [T_W-1:0]          t;
  logic [T_W:0]            t_up;
  logic [T_W-1:0]          u_d, u_q;
  logic [PROD_W-1:0]       prod;
  logic [RAW_W-1:0]        raw_d, raw_q;

  // x*Q + P*65536
  assign lin_d = LIN_W'(x_i) * $signed({34'd0, cfg.q}) + $signed({13'd0, cfg.off});

  // clamp, then floor(t*65535/65536) = t - ceil(t/65536)
  always_comb begin
    if (lin_q[LIN_W-1]) begin
      t = '0;
    end else if (lin_q > $signed({12'd0, cfg.hi})) begin
      t = cfg.hi;
    end else begin
      t = lin_q[T_W-1:0];
    end
    t_up = {1'b0, t} + (T_W+1)'(65535);
    u_d  = t - T_W'(t_up >> 16);
  end

  // exact floor(u/S) by reciprocal
  assign prod  = {{M_W{1'b0}}, u_q} * {{T_W{1'b0}}, cfg.m};
  assign raw_d = RAW_W'(prod >> cfg.k);

  always_ff @(posedge clk_i) begin
    if (en_i.s1) begin
      lin_q <= lin_d;
    end
    if (en_i.s2) begin
      u_q <= u_d;
    end
    if (en_i.s3) begin
      raw_q <= raw_d;
    end
  end

  assign raw_o = raw_q;

endmodule
`default_nettype wire

[hdl/mcfe_merge.sv]
`default_nettype none
module mcfe_merge import mcfe_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       en_i,
  input  wire side_t      side_i,
  input  wire raw_vec_t   raw_i,
  input  wire logic [7:0] host_addr_i,
  output logic [28:0]     frame_id_o,
  output logic [63:0]     frame_payload_o
);

  logic [28:0] id_d, id_q;
  logic [63:0] pay_d, pay_q;

  always_comb begin
    id_d  = {TYPE_ZERO, 8'd0, host_addr_i, side_i.addr};
    pay_d = {8'd1, 56'd0};
    case (side_i.mode)
      MODE_MOTION: begin
        id_d  = {TYPE_MOTION, raw_i[LANE_TORQUE], side_i.addr};
        pay_d = {raw_i[LANE_ANGLE], raw_i[LANE_VELOCITY], raw_i[LANE_KP], raw_i[LANE_KD]};
      end
      MODE_ENABLE: begin
        id_d  = {TYPE_ENABLE, 8'd0, host_addr_i, side_i.addr};
        pay_d = '0;
      end
      MODE_DISABLE: begin
        id_d  = {TYPE_DISABLE, 8'd0, host_addr_i, side_i.addr};
        pay_d = {7'd0, side_i.cf, 56'd0};
      end
      MODE_ZERO: begin
        id_d  = {TYPE_ZERO, 8'd0, host_addr_i, side_i.addr};
        pay_d = {8'd1, 56'd0};
      end
      default: begin
        id_d  = {TYPE_ZERO, 8'd0, host_addr_i, side_i.addr};
        pay_d = {8'd1, 56'd0};
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      id_q  <= id_d;
      pay_q <= pay_d;
    end
  end

  assign frame_id_o      = id_q;
  assign frame_payload_o = pay_q;

endmodule
`default_nettype wire

[hdl/motor_command_frame_encoder.sv]
`default_nettype none
// channel    | dir | handshake     | payload
// cmd_i      | in  | valid / ready | mode, motor_address, fault_clr, 5 x Q16.16 setpoints
// frame_o    | out | valid / ready | frame_id[28:0], frame_payload[63:0]
// cfg        | in  | cfg_we_i      | cfg_wdata_i = host_address
//
// One item per cycle unless every stage is full and frame_o stalls. An item passes
// four registers in order (offset multiply, clamp/rescale, reciprocal multiply,
// merge). Each stage holds its own valid bit and fills bubbles, so items keep
// entering while a result waits on frame_o, until every stage holds an item.
// Reset clears the valid bits and host_address.
module motor_command_frame_encoder import mcfe_pkg::*; (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  mcfe_cmd_if.sink    cmd_i,
  mcfe_frame_if.source frame_o,
  input  wire logic   cfg_we_i,
  input  wire logic [7:0] cfg_wdata_i
);

  logic [7:0] host_q;
  logic       v1_q, v2_q, v3_q, vo_q;
  side_t      side1_q, side2_q, side3_q;
  stage_en_t  en;
  raw_vec_t   raw;
  logic signed [31:0] lane_x [NUM_LANES];

  always_comb begin
    en.so = !vo_q || frame_o.ready;
    en.s3 = !v3_q || en.so;
    en.s2 = !v2_q || en.s3;
    en.s1 = !v1_q || en.s2;
  end

  assign cmd_i.ready = en.s1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      host_q <= '0;
      v1_q   <= 1'b0;
      v2_q   <= 1'b0;
      v3_q   <= 1'b0;
      vo_q   <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        host_q <= cfg_wdata_i;
      end
      if (en.s1) begin
        v1_q <= cmd_i.valid;
      end
      if (en.s2) begin
        v2_q <= v1_q;
      end
      if (en.s3) begin
        v3_q <= v2_q;
      end
      if (en.so) begin
        vo_q <= v3_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en.s1) begin
      side1_q <= '{mode: mode_e'(cmd_i.mode), addr: cmd_i.motor_address,
                   cf: cmd_i.fault_clr};
    end
    if (en.s2) begin
      side2_q <= side1_q;
    end
    if (en.s3) begin
      side3_q <= side2_q;
    end
  end

  assign lane_x[LANE_TORQUE]   = cmd_i.torque_cmd;
  assign lane_x[LANE_ANGLE]    = cmd_i.angle_cmd;
  assign lane_x[LANE_VELOCITY] = cmd_i.velocity_cmd;
  assign lane_x[LANE_KP]       = cmd_i.stiffness_gain;
  assign lane_x[LANE_KD]       = cmd_i.damping_gain;

  for (genvar g = 0; g < NUM_LANES; g++) begin : g_lane
    mcfe_lane u_lane (
      .clk_i  (clk_i),
      .lane_i (lane_e'(g)),
      .en_i   (en),
      .x_i    (lane_x[g]),
      .raw_o  (raw[g])
    );
  end

  mcfe_merge u_merge (
    .clk_i           (clk_i),
    .en_i            (en.so),
    .side_i          (side3_q),
    .raw_i           (raw),
    .host_addr_i     (host_q),
    .frame_id_o      (frame_o.frame_id),
    .frame_payload_o (frame_o.frame_payload)
  );

  assign frame_o.valid = vo_q;

endmodule
`default_nettype wire

[tb/sv/tb_motor_command_frame_encoder.sv]
`default_nettype none
module tb_motor_command_frame_encoder;
  timeunit 1ns;
  timeprecision 1ps;
  import mcfe_pkg::*;

  localparam int CYCLE_LIMIT  = 400000;
  localparam int DRAIN_CYCLES = 8;

  // setpoint ranges in Q16.16; the angle bound is rounded up past 12.57
  localparam int TQ_LIM = 60 * 65536;
  localparam int AN_LIM = 823788;
  localparam int VE_LIM = 20 * 65536;
  localparam int KP_LIM = 5000 * 65536;
  localparam int KD_LIM = 100 * 65536;

  typedef struct packed {
    mode_e       mode;
    logic [7:0]  addr;
    logic        cf;
    logic [31:0] tq;
    logic [31:0] an;
    logic [31:0] ve;
    logic [31:0] kp;
    logic [31:0] kd;
  } cmd_t;

  typedef struct packed {
    logic [28:0] id;
    logic [63:0] payload;
  } frame_t;

  class frame_scoreboard;
    logic [7:0] host_addr;
    frame_t     expected_q[$];
    int         errors;

    function new();
      host_addr = '0;
      errors    = 0;
    endfunction

    // map clamp(x*q + p, 0, 2p) onto 0..65535 with an exact floor
    function logic [15:0] scale_symmetric(logic [31:0] x, longint p, longint q);
      longint span;
      longint t;
      span = 2 * p * 65536;
      t = longint'(signed'(x)) * q + p * 65536;
      if (t < 0) t = 0;
      if (t > span) t = span;
      return 16'((t * 65535) / span);
    endfunction

    function logic [15:0] scale_gain(logic [31:0] x, longint p);
      longint span;
      longint t;
      span = p * 65536;
      t = longint'(signed'(x));
      if (t < 0) t = 0;
      if (t > span) t = span;
      return 16'((t * 65535) / span);
    endfunction

    function frame_t encode_frame(cmd_t c);
      frame_t f;
      case (c.mode)
        MODE_MOTION: begin
          f.id = {TYPE_MOTION, scale_symmetric(c.tq, 60, 1), c.addr};
          f.payload = {scale_symmetric(c.an, 1257, 100), scale_symmetric(c.ve, 20, 1),
                       scale_gain(c.kp, 5000), scale_gain(c.kd, 100)};
        end
        MODE_ENABLE: begin
          f.id = {TYPE_ENABLE, 8'h00, host_addr, c.addr};
          f.payload = '0;
        end
        MODE_DISABLE: begin
          f.id = {TYPE_DISABLE, 8'h00, host_addr, c.addr};
          f.payload = {7'd0, c.cf, 56'd0};
        end
        default: begin
          f.id = {TYPE_ZERO, 8'h00, host_addr, c.addr};
          f.payload = {8'h01, 56'd0};
        end
      endcase
      return f;
    endfunction

    task report(string msg);
      errors++;
      $display("ERROR: %s", msg);
    endtask

    task note_cmd(cmd_t c);
      expected_q.push_back(encode_frame(c));
    endtask

    task check_frame(frame_t got);
      frame_t want;
      if (expected_q.size() == 0) begin
        report($sformatf("frame id %h with no command pending", got.id));
        return;
      end
      want = expected_q.pop_front();
      if (got.id !== want.id)
        report($sformatf("frame_id %h, expected %h", got.id, want.id));
      if (got.payload !== want.payload)
        report($sformatf("frame_payload %h, expected %h", got.payload, want.payload));
    endtask
  endclass

  logic       clk_i = 1'b0;
  logic       rst_ni;
  logic       cfg_we_i;
  logic [7:0] cfg_wdata_i;
  int         cycle_count = 0;
  int         stall_style = 0;
  int         stall_left  = 0;

  mcfe_cmd_if   cmd_bus ();
  mcfe_frame_if frame_bus ();

  frame_scoreboard sb = new();

  motor_command_frame_encoder i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd_bus),
    .frame_o     (frame_bus),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("FAIL");
    $finish;
  end

  // receiver stall pattern: picks a new random style each time stall_left runs out
  always @(negedge clk_i) begin
    if (stall_left == 0) begin
      stall_style = $urandom_range(0, 3);
      stall_left  = $urandom_range(20, 120);
    end
    stall_left--;
    case (stall_style)
      0: frame_bus.ready = 1'b1;
      1: frame_bus.ready = ($urandom_range(0, 1) == 1);
      2: frame_bus.ready = ((stall_left % 24) < 3);
      default: frame_bus.ready = ($urandom_range(0, 9) != 0);
    endcase
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (frame_bus.valid && frame_bus.ready)
        sb.check_frame('{frame_bus.frame_id, frame_bus.frame_payload});
      if (cmd_bus.valid && cmd_bus.ready)
        sb.note_cmd('{mode_e'(cmd_bus.mode), cmd_bus.motor_address, cmd_bus.fault_clr,
                      cmd_bus.torque_cmd, cmd_bus.angle_cmd, cmd_bus.velocity_cmd,
                      cmd_bus.stiffness_gain, cmd_bus.damping_gain});
    end
  end

  task automatic send_cmd(cmd_t c);
    @(negedge clk_i);
    cmd_bus.valid          = 1'b1;
    cmd_bus.mode           = c.mode;
    cmd_bus.motor_address  = c.addr;
    cmd_bus.fault_clr      = c.cf;
    cmd_bus.torque_cmd     = c.tq;
    cmd_bus.angle_cmd      = c.an;
    cmd_bus.velocity_cmd   = c.ve;
    cmd_bus.stiffness_gain = c.kp;
    cmd_bus.damping_gain   = c.kd;
    do @(posedge clk_i); while (!cmd_bus.ready);
  endtask

  task automatic idle_cmd(int n);
    repeat (n) begin
      @(negedge clk_i);
      cmd_bus.valid      = 1'b0;
      cmd_bus.mode       = 2'($urandom());
      cmd_bus.torque_cmd = $urandom();
    end
  endtask

  task automatic write_host(logic [7:0] value);
    @(negedge clk_i);
    cmd_bus.valid = 1'b0;
    while (sb.expected_q.size() != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
    cfg_we_i    = 1'b1;
    cfg_wdata_i = value;
    @(negedge clk_i);
    cfg_we_i    = 1'b0;
    cfg_wdata_i = 8'($urandom());
    sb.host_addr = value;
  endtask

  function automatic logic [31:0] pick_setpoint(longint lo, longint hi);
    case ($urandom_range(0, 5))
      0: return $urandom();
      1: return 32'(lo + longint'($urandom_range(0, 2)) - 1);
      2: return 32'(hi + longint'($urandom_range(0, 2)) - 1);
      3: return 32'(longint'($urandom_range(0, 131072)) - 65536);
      default: return 32'(lo + longint'($urandom_range(0, 32'(hi - lo))));
    endcase
  endfunction

  function automatic cmd_t rand_cmd();
    cmd_t c;
    c.mode = ($urandom_range(0, 9) < 6) ? MODE_MOTION : mode_e'($urandom_range(1, 3));
    c.addr = 8'($urandom());
    c.cf   = 1'($urandom());
    c.tq   = pick_setpoint(-TQ_LIM, TQ_LIM);
    c.an   = pick_setpoint(-AN_LIM, AN_LIM);
    c.ve   = pick_setpoint(-VE_LIM, VE_LIM);
    c.kp   = pick_setpoint(0, KP_LIM);
    c.kd   = pick_setpoint(0, KD_LIM);
    return c;
  endfunction

  task automatic run_random(int n);
    int burst;
    burst = 0;
    repeat (n) begin
      if (burst == 0) begin
        burst = $urandom_range(1, 40);
        if ($urandom_range(0, 3) != 0) idle_cmd($urandom_range(1, 12));
      end
      burst--;
      send_cmd(rand_cmd());
    end
  endtask

  initial begin
    logic [7:0] host_list[5];
    host_list = '{8'h00, 8'hFF, 8'h5A, 8'($urandom()), 8'($urandom())};
    rst_ni                 = 1'b0;
    cfg_we_i               = 1'b0;
    cfg_wdata_i            = '0;
    cmd_bus.valid          = 1'b0;
    cmd_bus.mode           = '0;
    cmd_bus.motor_address  = '0;
    cmd_bus.fault_clr      = 1'b0;
    cmd_bus.torque_cmd     = '0;
    cmd_bus.angle_cmd      = '0;
    cmd_bus.velocity_cmd   = '0;
    cmd_bus.stiffness_gain = '0;
    cmd_bus.damping_gain   = '0;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    write_host(8'hA5);
    send_cmd('{MODE_MOTION, 8'h00, 1'b0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0});
    send_cmd('{MODE_MOTION, 8'hFF, 1'b1, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF,
               32'h7FFFFFFF, 32'h7FFFFFFF});
    send_cmd('{MODE_MOTION, 8'h5C, 1'b0, 32'h80000000, 32'h80000000, 32'h80000000,
               32'h80000000, 32'h80000000});
    // exactly at the range ends (angle at the nearest values inside its range)
    send_cmd('{MODE_MOTION, 8'h01, 1'b0, 32'(TQ_LIM), 32'(AN_LIM - 1), 32'(VE_LIM),
               32'(KP_LIM), 32'(KD_LIM)});
    send_cmd('{MODE_MOTION, 8'h02, 1'b0, 32'(-TQ_LIM), 32'(1 - AN_LIM), 32'(-VE_LIM),
               32'd0, 32'd0});
    // just past the range ends, negative gains
    send_cmd('{MODE_MOTION, 8'h03, 1'b0, 32'(TQ_LIM + 1), 32'(AN_LIM), 32'(VE_LIM + 1),
               32'(KP_LIM + 1), 32'(KD_LIM + 1)});
    send_cmd('{MODE_MOTION, 8'h04, 1'b1, 32'(-TQ_LIM - 1), 32'(-AN_LIM), 32'(-VE_LIM - 1),
               32'hFFFFFFFF, 32'hFFFFFFFF});
    send_cmd('{MODE_MOTION, 8'h80, 1'b0, 32'd1, 32'hFFFFFFFF, 32'd65536, 32'd1, 32'd1});
    send_cmd('{MODE_ENABLE, 8'h00, 1'b1, 32'h12345678, 32'h9ABCDEF0, 32'hFFFFFFFF,
               32'h7FFFFFFF, 32'h80000000});
    send_cmd('{MODE_ENABLE, 8'hFF, 1'b0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0});
    send_cmd('{MODE_DISABLE, 8'h12, 1'b0, 32'hDEADBEEF, 32'd0, 32'd0, 32'd0, 32'd0});
    send_cmd('{MODE_DISABLE, 8'hFF, 1'b1, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0});
    send_cmd('{MODE_ZERO, 8'h7E, 1'b0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0});
    send_cmd('{MODE_ZERO, 8'h00, 1'b1, 32'hFFFFFFFF, 32'h7FFFFFFF, 32'h80000000,
               32'hAAAAAAAA, 32'h55555555});

    foreach (host_list[i]) begin
      write_host(host_list[i]);
      run_random(188);
    end

    @(negedge clk_i);
    cmd_bus.valid = 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (sb.errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
`default_nettype wire
